FILE: rtl/core/rcots_pkg.sv
package rcots_pkg;

  // Widths of the payload fields and registers.
  localparam int unsigned TickW   = 25;
  localparam int unsigned WinW    = 24;
  localparam int unsigned TrimW   = 8;
  localparam int unsigned StepW   = 7;
  localparam int unsigned NbW     = 4;
  localparam int unsigned OvfW    = 16;
  localparam int unsigned LowCntW = 8;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values.
  localparam logic [WinW-1:0]  WindowLowRst  = 24'd123750;
  localparam logic [WinW-1:0]  WindowHighRst = 24'd126250;
  localparam logic [TrimW-1:0] FactoryTrimRst = 8'd0;
  localparam logic [NbW-1:0]   NbChecksRst   = 4'd5;

  // Search constants.
  localparam logic [TrimW-1:0] TrimStart   = 8'd127;
  localparam logic [StepW-1:0] StepStart   = 7'd127;
  localparam logic [TrimW-1:0] NbClampLow  = 8'd2;
  localparam logic [TrimW-1:0] NbClampHigh = 8'd253;
  localparam logic [TrimW-1:0] NbHighStart = 8'd250;

  // Item action codes.
  localparam logic ActStart   = 1'b0;
  localparam logic ActMeasure = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LOW  = 2'd0,
    CFG_WINDOW_HIGH = 2'd1,
    CFG_FACTORY     = 2'd2,
    CFG_NB_CHECKS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_MEASURE = 2'd0,
    ST_PASS    = 2'd1,
    ST_FAIL    = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef struct packed {
    logic               action;
    logic [OvfW-1:0]    overflow_count;
    logic [LowCntW-1:0] timer_count;
    logic               overflow_pending;
  } in_item_t;

  typedef struct packed {
    logic [TrimW-1:0] trim;
    logic [1:0]       status;
    logic [TickW-1:0] measured_ticks;
  } out_item_t;

  typedef struct packed {
    logic [WinW-1:0]  window_low;
    logic [WinW-1:0]  window_high;
    logic [TrimW-1:0] factory_trim;
    logic [NbW-1:0]   neighbour_checks;
  } cfg_regs_t;

endpackage

FILE: rtl/core/rcots_cfg.sv
module rcots_cfg
  import rcots_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [31:0]        wr_data,
  output cfg_regs_t          regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the register index of a write beat.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_WINDOW_LOW:  regs_nxt.window_low       = wr_data[WinW-1:0];
        CFG_WINDOW_HIGH: regs_nxt.window_high      = wr_data[WinW-1:0];
        CFG_FACTORY:     regs_nxt.factory_trim     = wr_data[TrimW-1:0];
        CFG_NB_CHECKS:   regs_nxt.neighbour_checks = wr_data[NbW-1:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.window_low       <= WindowLowRst;
      regs_r.window_high      <= WindowHighRst;
      regs_r.factory_trim     <= FactoryTrimRst;
      regs_r.neighbour_checks <= NbChecksRst;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

FILE: rtl/core/rcots_engine.sv
module rcots_engine
  import rcots_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  logic             active_r, active_nxt;
  logic [TrimW-1:0] trim_r, trim_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [NbW-1:0]   nb_cnt_r, nb_cnt_nxt;
  logic [TickW-1:0] last_ticks_r, last_ticks_nxt;

  logic [TickW-1:0] ticks;
  logic [StepW-1:0] step_half;
  logic             below_low;
  logic             in_window;
  status_t          status;
  logic [TickW-1:0] ticks_out;

  // Tick count: overflows times 256 plus the low count, plus a pending overflow.
  assign ticks = {1'b0, item.overflow_count, 8'h00}
               + {{(TickW-LowCntW){1'b0}}, item.timer_count}
               + {{(TickW-9){1'b0}}, item.overflow_pending, 8'h00};

  assign step_half = step_r >> 1;
  assign below_low = ticks < {1'b0, cfg.window_low};
  assign in_window = !below_low && (ticks <= {1'b0, cfg.window_high});

  // One search step for the item at the head of the pipeline.
  always_comb begin
    active_nxt     = active_r;
    trim_nxt       = trim_r;
    step_nxt       = step_r;
    nb_cnt_nxt     = nb_cnt_r;
    last_ticks_nxt = last_ticks_r;
    status         = ST_MEASURE;
    ticks_out      = last_ticks_r;
    if (item.action == ActStart) begin
      active_nxt = 1'b1;
      step_nxt   = StepStart;
      trim_nxt   = TrimStart;
      nb_cnt_nxt = '0;
    end else if (!active_r) begin
      status = ST_IDLE;
    end else begin
      last_ticks_nxt = ticks;
      step_nxt       = step_half;
      ticks_out      = ticks;
      if (in_window) begin
        active_nxt = 1'b0;
        status     = ST_PASS;
      end else if (step_half != '0) begin
        if (below_low) begin
          trim_nxt = trim_r + {1'b0, step_half};
        end else begin
          trim_nxt = trim_r - {1'b0, step_half};
        end
      end else if (nb_cnt_r < cfg.neighbour_checks) begin
        // Neighbour scan starts two below (clamped near the ends of the trim range) and then walks upward.
        if (nb_cnt_r == '0) begin
          if (trim_r < NbClampLow) begin
            trim_nxt = '0;
          end else if (trim_r > NbClampHigh) begin
            trim_nxt = NbHighStart;
          end else begin
            trim_nxt = trim_r - NbClampLow;
          end
        end else begin
          trim_nxt = trim_r + 8'd1;
        end
        nb_cnt_nxt = nb_cnt_r + 4'd1;
      end else begin
        trim_nxt   = cfg.factory_trim;
        active_nxt = 1'b0;
        status     = ST_FAIL;
      end
    end
  end

  assign result.trim           = trim_nxt;
  assign result.status         = status;
  assign result.measured_ticks = ticks_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      trim_r       <= '0;
      step_r       <= '0;
      nb_cnt_r     <= '0;
      last_ticks_r <= '0;
    end else if (en) begin
      active_r     <= active_nxt;
      trim_r       <= trim_nxt;
      step_r       <= step_nxt;
      nb_cnt_r     <= nb_cnt_nxt;
      last_ticks_r <= last_ticks_nxt;
    end
  end

  // A start beat always leaves a fresh search behind it.
  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == ActStart |=>
      active_r && step_r == StepStart && trim_r == TrimStart && nb_cnt_r == '0)
    else $error("search not initialized after start");

  // The neighbour scan only runs once the binary step is exhausted.
  a_nb_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    nb_cnt_r != '0 |-> step_r == '0)
    else $error("neighbour scan with nonzero step");

  // A measurement while idle leaves the search state alone.
  a_idle_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    en && !active_r && item.action == ActMeasure |=>
      $stable(trim_r) && $stable(last_ticks_r) && !active_r)
    else $error("idle measurement changed state");

  // The search only ends on an accepted beat.
  a_end_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> $past(en))
    else $error("search ended without a beat");

endmodule

FILE: rtl/core/rc_oscillator_trim_search.sv
// Channel | Signals                          | Direction | Beat when
// in      | in_valid, in_stall, in_data      | input     | in_valid && !in_stall
// out     | out_valid, out_stall, out_data   | output    | out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_index, | input     | cfg_valid && cfg_ready
//         | cfg_data                         |           |
//
// An item is latched in an input register, then one search step is computed and the
// result lands in the output register. One item per cycle is sustained while the output
// does not stall, as the search engine updates its state once for each accepted item.
// Reset is synchronous and active low; it clears the search state and restores the
// register defaults. A stalled output holds its result and backs up into in_stall.
module rc_oscillator_trim_search
  import rcots_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      advance;
  logic      in_take;
  cfg_regs_t cfg_regs;
  out_item_t result;

  // The head item moves on when the output register is free or being drained.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  rcots_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  rcots_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .item   (in_item_r),
    .cfg    (cfg_regs),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
